// ----- design/tocm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tocm_pkg;

   // Geometry
   localparam int TILE_SIZE     = 16;
   localparam int GRID_TILES_X  = 64;
   localparam int GRID_TILES_Y  = 64;
   localparam int SUBPIX        = 16;
   localparam int MAX_IMAGE_DIM = 1024;

   // Field widths
   localparam int KIND_W     = 2;
   localparam int ALPHA_W    = 8;
   localparam int COORD_W    = 15;
   localparam int DIM_W      = 11;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam int TILE_SHIFT = $clog2(TILE_SIZE);
   localparam int SPAN_SHIFT = $clog2(TILE_SIZE * SUBPIX);
   localparam int TX_W       = (GRID_TILES_X > 1) ? $clog2(GRID_TILES_X) : 1;
   localparam int TY_W       = (GRID_TILES_Y > 1) ? $clog2(GRID_TILES_Y) : 1;
   localparam int TIDX_W     = (TX_W > TY_W) ? TX_W : TY_W;
   localparam int SUM_W      = COORD_W + 2;

   // Transaction kinds
   localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd2;

   typedef enum logic [3:0] {
      Q_IDLE = 4'b0001,
      Q_WALK = 4'b0010,
      Q_LAST = 4'b0100,
      Q_HOLD = 4'b1000
   } q_state_type;

   typedef struct packed {
      logic              empty;
      logic [TIDX_W-1:0] first;
      logic [TIDX_W-1:0] last;
   } axis_range_type;

endpackage

`default_nettype wire

// ----- design/tocm_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tocm_req_if import tocm_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [ALPHA_W-1:0]        alpha;
   logic signed [COORD_W-1:0] query_x;
   logic signed [COORD_W-1:0] query_y;
   logic [COORD_W-1:0]        query_w;
   logic [COORD_W-1:0]        query_h;

   modport source (output valid, kind, alpha, query_x, query_y, query_w, query_h,
                   input ready);
   modport sink   (input valid, kind, alpha, query_x, query_y, query_w, query_h,
                   output ready);
endinterface

interface tocm_rsp_if;
   logic valid;
   logic ready;
   logic collides;

   modport source (output valid, collides, input ready);
   modport sink   (input valid, collides, output ready);
endinterface

`default_nettype wire

// ----- design/tile_occupancy_collision_map_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tile occupancy collision map. Pixel alpha transactions arrive in raster order;
// the core tracks column and row itself and marks a tile solid when any pixel in
// it has alpha above csr alpha_threshold. The tile bitmap lives in a one-port-
// read, one-port-write RAM with one word per tile row. Pixels stream back to
// back while no query is in progress: the row word is read when the pixel is
// taken and written back with the tile bit set in the next cycle, with forwarding
// of the word just written. A restart clears the map through a per-row valid
// bit, so there is no clearing pass after reset or restart. A query does one
// RAM read per tile row that its clamped rectangle covers, and none when it is
// empty or off the grid. Its one-bit answer goes to an output register, so
// the next transaction is taken while the answer waits on rsp_chan.
// Configuration registers must only be written while the core is idle.

module tile_occupancy_collision_map_core import tocm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   tocm_req_if.sink                   req_chan,
   tocm_rsp_if.source                 rsp_chan
);

   // Clamp a span [lo, lo+len) in 1/16 pixels to tile indexes; empty when
   // no tile interior is covered.
   function automatic axis_range_type axis_range(
      input logic [COORD_W-1:0] lo,
      input logic [COORD_W-1:0] len,
      input logic [SUM_W-1:0]   ntiles
   );
      logic [SUM_W-1:0] hi;
      logic [SUM_W-1:0] hi_m1;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
      axis_range_type   r;
      hi    = {{(SUM_W-COORD_W){lo[COORD_W-1]}}, lo} + {{(SUM_W-COORD_W){1'b0}}, len};
      hi_m1 = hi - SUM_W'(1);
      a     = lo[COORD_W-1] ? '0 : ({{(SUM_W-COORD_W){1'b0}}, lo} >> SPAN_SHIFT);
      b     = hi_m1 >> SPAN_SHIFT;
      if (b >= ntiles) begin
         b = ntiles - SUM_W'(1);
      end
      r.empty = (len == '0) || hi[SUM_W-1] || (hi == '0) || (a >= ntiles);
      r.first = a[TIDX_W-1:0];
      r.last  = b[TIDX_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [ALPHA_W-1:0] threshold_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         width_ff     <= DIM_W'(MAX_IMAGE_DIM);
         height_ff    <= DIM_W'(MAX_IMAGE_DIM);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA_THRESHOLD: threshold_ff <= csr_wdata[ALPHA_W-1:0];
            CSR_IMAGE_WIDTH:     width_ff     <= csr_wdata;
            CSR_IMAGE_HEIGHT:    height_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Zero acts as one, anything above the maximum as the maximum.
   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;

   always_comb begin
      width_eff  = width_ff;
      height_eff = height_ff;
      if (width_ff == '0)                     width_eff  = DIM_W'(1);
      if (width_ff > DIM_W'(MAX_IMAGE_DIM))   width_eff  = DIM_W'(MAX_IMAGE_DIM);
      if (height_ff == '0)                    height_eff = DIM_W'(1);
      if (height_ff > DIM_W'(MAX_IMAGE_DIM))  height_eff = DIM_W'(MAX_IMAGE_DIM);
   end

   // ---------------------------------------------------------------------
   // Handshake decode
   // ---------------------------------------------------------------------
   q_state_type state_ff, state_in;

   logic take;
   logic take_pixel;
   logic take_query;
   logic take_restart;

   assign req_chan.ready = (state_ff == Q_IDLE);
   assign take           = req_chan.valid && req_chan.ready;
   assign take_pixel     = take && (req_chan.kind == KIND_PIXEL);
   assign take_query     = take && (req_chan.kind == KIND_QUERY);
   assign take_restart   = take && (req_chan.kind == KIND_RESTART);

   // ---------------------------------------------------------------------
   // Raster position
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_next;
   logic [DIM_W-1:0] row_next;

   assign col_next = {1'b0, col_ff} + DIM_W'(1);
   assign row_next = {1'b0, row_ff} + DIM_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (take_pixel) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? '0 : row_next[POS_W-1:0];
         end else begin
            col_in = col_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Tile of the current pixel; pixels past the grid mark nothing.
   logic [POS_W-1:0] tx_full;
   logic [POS_W-1:0] ty_full;
   logic             pix_in_grid;
   logic             pix_solid;

   assign tx_full     = col_ff >> TILE_SHIFT;
   assign ty_full     = row_ff >> TILE_SHIFT;
   assign pix_in_grid = (tx_full < POS_W'(GRID_TILES_X)) && (ty_full < POS_W'(GRID_TILES_Y));
   assign pix_solid   = (req_chan.alpha > threshold_ff) && pix_in_grid;

   // ---------------------------------------------------------------------
   // Tile bitmap RAM, one word per tile row
   // ---------------------------------------------------------------------
   logic                    ram_we;
   logic [TY_W-1:0]         ram_waddr;
   logic [GRID_TILES_X-1:0] ram_wdata;
   logic [TY_W-1:0]         ram_raddr;
   logic [GRID_TILES_X-1:0] ram_rdata;

   tocm_ram #(
      .WIDTH (GRID_TILES_X),
      .DEPTH (GRID_TILES_Y)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Row valid bits: a row not written since reset or restart reads as zero.
   logic [GRID_TILES_Y-1:0] row_valid_ff, row_valid_in;

   // Read tag: row of the read in flight, and the write that hit it.
   logic [TY_W-1:0]         rd_row_ff;
   logic                    rd_query_ff;
   logic                    fwd_ff;
   logic [GRID_TILES_X-1:0] fwd_data_ff;
   logic [GRID_TILES_X-1:0] rd_word;

   // Pixel write-back stage
   logic                    s1_set_ff;
   logic [TY_W-1:0]         s1_row_ff;
   logic [TX_W-1:0]         s1_col_ff;

   // Query walk registers
   logic [TY_W-1:0]         qy_cur_ff, qy_cur_in;
   logic [TY_W-1:0]         qy_last_ff, qy_last_in;
   logic [TX_W-1:0]         qx_first_ff, qx_first_in;
   logic [TX_W-1:0]         qx_last_ff, qx_last_in;

   assign ram_raddr = take_pixel ? ty_full[TY_W-1:0] : qy_cur_ff;

   // Forward the word written at the edge the read was issued.
   assign rd_word = fwd_ff ? fwd_data_ff :
                    (row_valid_ff[rd_row_ff] ? ram_rdata : '0);

   assign ram_we    = s1_set_ff;
   assign ram_waddr = s1_row_ff;
   assign ram_wdata = rd_word | (GRID_TILES_X'(1) << s1_col_ff);

   always_comb begin
      row_valid_in = row_valid_ff;
      if (take_restart) begin
         row_valid_in = '0;
      end else if (ram_we) begin
         row_valid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         s1_set_ff    <= 1'b0;
         rd_query_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         s1_set_ff    <= take_pixel && pix_solid;
         rd_query_ff  <= (state_ff == Q_WALK);
         fwd_ff       <= ram_we && (ram_waddr == ram_raddr);
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff   <= ty_full[TY_W-1:0];
      s1_col_ff   <= tx_full[TX_W-1:0];
      rd_row_ff   <= ram_raddr;
      fwd_data_ff <= ram_wdata;
   end

   // ---------------------------------------------------------------------
   // Query walk: one tile row per cycle
   // ---------------------------------------------------------------------
   axis_range_type x_rng;
   axis_range_type y_rng;

   assign x_rng = axis_range(req_chan.query_x, req_chan.query_w, SUM_W'(GRID_TILES_X));
   assign y_rng = axis_range(req_chan.query_y, req_chan.query_h, SUM_W'(GRID_TILES_Y));

   logic [GRID_TILES_X-1:0] xmask;

   always_comb begin
      for (int i = 0; i < GRID_TILES_X; i++) begin
         xmask[i] = (TX_W'(i) >= qx_first_ff) && (TX_W'(i) <= qx_last_ff);
      end
   end

   logic hit_ff, hit_in;
   logic hit_acc;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_collides_ff, rsp_collides_in;
   logic slot_free;

   assign hit_acc   = hit_ff || (rd_query_ff && ((rd_word & xmask) != '0));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in        = state_ff;
      qy_cur_in       = qy_cur_ff;
      qy_last_in      = qy_last_ff;
      qx_first_in     = qx_first_ff;
      qx_last_in      = qx_last_ff;
      hit_in          = hit_acc;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_collides_in = rsp_collides_ff;
      case (state_ff)
         Q_IDLE: begin
            if (take_query) begin
               hit_in      = 1'b0;
               qy_cur_in   = y_rng.first[TY_W-1:0];
               qy_last_in  = y_rng.last[TY_W-1:0];
               qx_first_in = x_rng.first[TX_W-1:0];
               qx_last_in  = x_rng.last[TX_W-1:0];
               state_in    = (x_rng.empty || y_rng.empty) ? Q_HOLD : Q_WALK;
            end
         end
         Q_WALK: begin
            if (qy_cur_ff == qy_last_ff) begin
               state_in = Q_LAST;
            end else begin
               qy_cur_in = qy_cur_ff + TY_W'(1);
            end
         end
         Q_LAST: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_collides_in = hit_acc;
               state_in        = Q_IDLE;
            end else begin
               state_in = Q_HOLD;
            end
         end
         Q_HOLD: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_collides_in = hit_ff;
               state_in        = Q_IDLE;
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Q_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qy_cur_ff       <= qy_cur_in;
      qy_last_ff      <= qy_last_in;
      qx_first_ff     <= qx_first_in;
      qx_last_ff      <= qx_last_in;
      hit_ff          <= hit_in;
      rsp_collides_ff <= rsp_collides_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.collides = rsp_collides_ff;

endmodule

`default_nettype wire

// ----- design/tocm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tocm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                               rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire
